### sv/olkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olkd_pkg;

  localparam int DefCapacity = 64;
  localparam int KeyW        = 32;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_KEY   = 3'd1,
    OP_DEL_FIRST = 3'd2,
    OP_DEL_LAST  = 3'd3,
    OP_DRAIN     = 3'd4
  } olkd_op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DRAINED   = 3'd4
  } olkd_status_t;

  typedef enum logic [2:0] {
    CMD_HOLD      = 3'd0,
    CMD_PUSH      = 3'd1,
    CMD_POP_FRONT = 3'd2,
    CMD_DEL_MATCH = 3'd3,
    CMD_TRIM      = 3'd4
  } olkd_cmd_t;

  typedef struct packed {
    olkd_cmd_t         cmd;
    logic [KeyW-1:0]   search_key;
  } olkd_ctrl_t;

endpackage

`default_nettype wire

### sv/olkd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface olkd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface olkd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] out_key;
  logic               last;

  modport source (output valid, output status, output out_key, output last, input ready);
  modport sink   (input valid, input status, input out_key, input last, output ready);
endinterface

`default_nettype wire

### sv/olkd_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module olkd_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire olkd_pkg::olkd_ctrl_t      ctrl,
  input  wire logic [olkd_pkg::KeyW-1:0] left_key,
  input  wire logic                      left_valid,
  input  wire logic [olkd_pkg::KeyW-1:0] right_key,
  input  wire logic                      right_valid,
  input  wire logic                      found_in,
  output logic [olkd_pkg::KeyW-1:0]      key,
  output logic                           valid,
  output logic                           found_out
);
  import olkd_pkg::*;

  logic [KeyW-1:0] key_r;
  logic [KeyW-1:0] key_nxt;
  logic            valid_r;
  logic            valid_nxt;
  logic            hit;

  always_comb begin
    hit       = valid_r && (key_r == ctrl.search_key);
    found_out = found_in || hit;
    key_nxt   = key_r;
    valid_nxt = valid_r;
    case (ctrl.cmd)
      CMD_PUSH: begin
        key_nxt   = left_key;
        valid_nxt = left_valid;
      end
      CMD_POP_FRONT: begin
        key_nxt   = right_key;
        valid_nxt = right_valid;
      end
      CMD_DEL_MATCH: begin
        if (found_out) begin
          key_nxt   = right_key;
          valid_nxt = right_valid;
        end
      end
      CMD_TRIM: begin
        valid_nxt = right_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

### sv/ordered_list_with_key_delete.sv
// Ordered list of signed 32-bit keys, front first, up to CAPACITY entries.
// Input channel in_ch carries an operation code and a key; output channel
// out_ch carries status, out_key and last, one valid/ready transfer each.
// Insert, delete-key, delete-first and delete-last each give one status
// result; the result sits in the output register in the cycle after the input
// transfer, and a new item is taken in that same cycle if no drain is running
// and the output register is empty or being taken.
// Every cell compares against the search key and shifts in the same cycle;
// the first-match flag ripples through the row of cells.
// Drain on a non-empty list sends one key per cycle from the front while
// the receiver takes them, with last on the final key; no input item is
// taken until the final key is loaded into the output register.
// When the receiver stalls, the output register holds and input is held off.
// Reset (rst_n low, synchronous) empties the list and the output register.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_with_key_delete #(
  parameter int CAPACITY = olkd_pkg::DefCapacity
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  olkd_in_if.sink    in_ch,
  olkd_out_if.source out_ch
);
  import olkd_pkg::*;

  logic [KeyW-1:0]   cell_key   [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY:0] found_chain;
  olkd_ctrl_t        ctrl;

  logic              out_valid_r;
  logic              out_valid_nxt;
  olkd_status_t      status_r;
  olkd_status_t      status_nxt;
  logic [KeyW-1:0]   out_key_r;
  logic [KeyW-1:0]   out_key_nxt;
  logic              last_r;
  logic              last_nxt;
  logic              drain_r;
  logic              drain_nxt;

  logic              slot_free;
  logic              in_fire;
  logic              list_empty;
  logic              list_full;
  logic              key_found;
  logic              drain_step;
  olkd_status_t      op_status;

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyW-1:0] lkey;
    logic            lvalid;
    logic [KeyW-1:0] rkey;
    logic            rvalid;

    if (i == 0) begin : g_left_in
      assign lkey   = in_ch.key;
      assign lvalid = 1'b1;
    end else begin : g_left_cell
      assign lkey   = cell_key[i-1];
      assign lvalid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_end
      assign rkey   = '0;
      assign rvalid = 1'b0;
    end else begin : g_right_cell
      assign rkey   = cell_key[i+1];
      assign rvalid = cell_valid[i+1];
    end

    olkd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_key   (lkey),
      .left_valid (lvalid),
      .right_key  (rkey),
      .right_valid(rvalid),
      .found_in   (found_chain[i]),
      .key        (cell_key[i]),
      .valid      (cell_valid[i]),
      .found_out  (found_chain[i+1])
    );
  end

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !drain_r && slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign list_empty  = !cell_valid[0];
  assign list_full   = cell_valid[CAPACITY-1];
  assign key_found   = found_chain[CAPACITY];
  assign drain_step  = slot_free &&
                       (drain_r || (in_fire && (in_ch.operation == OP_DRAIN) && !list_empty));

  always_comb begin
    ctrl.cmd        = CMD_HOLD;
    ctrl.search_key = in_ch.key;
    op_status       = ST_DONE;
    case (in_ch.operation)
      OP_INSERT: begin
        op_status = list_full ? ST_FULL : ST_DONE;
      end
      OP_DEL_KEY: begin
        op_status = key_found ? ST_DONE : ST_NOT_FOUND;
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DRAIN: begin
        op_status = list_empty ? ST_EMPTY : ST_DONE;
      end
      default: begin
        op_status = ST_DONE;
      end
    endcase

    if (drain_step) begin
      ctrl.cmd = CMD_POP_FRONT;
    end else if (in_fire) begin
      case (in_ch.operation)
        OP_INSERT: begin
          if (!list_full) ctrl.cmd = CMD_PUSH;
        end
        OP_DEL_KEY: begin
          if (key_found) ctrl.cmd = CMD_DEL_MATCH;
        end
        OP_DEL_FIRST: begin
          if (!list_empty) ctrl.cmd = CMD_POP_FRONT;
        end
        OP_DEL_LAST: begin
          if (!list_empty) ctrl.cmd = CMD_TRIM;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    out_key_nxt   = out_key_r;
    last_nxt      = last_r;
    drain_nxt     = drain_r;
    if (drain_step) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DRAINED;
      out_key_nxt   = cell_key[0];
      last_nxt      = !cell_valid[1];
      drain_nxt     = cell_valid[1];
    end else if (in_fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = op_status;
      out_key_nxt   = '0;
      last_nxt      = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      drain_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      drain_r     <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    out_key_r <= out_key_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = status_r;
  assign out_ch.out_key = out_key_r;
  assign out_ch.last    = last_r;

endmodule

`default_nettype wire

### sv/olkd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module olkd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_key,
  input wire logic        out_last
);
  import olkd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_key))
    else $error("result changed while stalled");

  a_status_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DRAINED) |-> (out_key == '0) && out_last)
    else $error("status result carries key or lacks last");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DRAINED) && !out_last |-> !in_ready)
    else $error("input taken during drain");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE) || (out_status == ST_FULL) ||
                  (out_status == ST_NOT_FOUND) || (out_status == ST_EMPTY) ||
                  (out_status == ST_DRAINED))
    else $error("undefined status code");

endmodule

bind ordered_list_with_key_delete olkd_checker u_olkd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .out_key   (out_ch.out_key),
  .out_last  (out_ch.last)
);

`default_nettype wire
